// ----- sv/mbe_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time unit.
package mbe_pkg;

    localparam int PIX_W     = 10;
    localparam int Q_W       = 32;
    localparam int STEP_W    = 31;
    localparam int CNT_W     = 16;
    localparam int FRAC      = 28;
    localparam int PROD_W    = 2 * Q_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_REAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_IMAG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd3;

    localparam logic signed [Q_W-1:0] CENTRE_RST = '0;
    localparam logic [STEP_W-1:0]     STEP_RST   = 31'd1048576;
    localparam logic [CNT_W-1:0]      LIMIT_RST  = 16'd100;

    // |z|^2 >= 4.0 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_MAG = 64'h0400_0000_0000_0000;

    typedef struct packed {
        logic signed [Q_W-1:0] centre_real;
        logic signed [Q_W-1:0] centre_imag;
        logic [STEP_W-1:0]     pixel_step;
        logic [CNT_W-1:0]      iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0]      px;
        logic [PIX_W-1:0]      py;
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
    } t_job;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [CNT_W-1:0] count;
        logic             in_set;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_UPD  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_CHK  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

endpackage

// ----- sv/mbe_front.sv -----
// Front end: accepts pixel coordinates and maps them to the complex constant c.
module mbe_front
    import mbe_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_px,
    input  logic [PIX_W-1:0] i_py,
    input  t_cfg             i_cfg,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_full
);

    localparam int HALF_X   = IMAGE_WIDTH / 2;
    localparam int HALF_Y   = IMAGE_HEIGHT / 2;
    localparam int HALF_MAX = (HALF_X > HALF_Y) ? HALF_X : HALF_Y;
    localparam int HALF_B   = $clog2(HALF_MAX + 1);
    localparam int OFF_W    = ((PIX_W > HALF_B) ? PIX_W : HALF_B) + 1;
    localparam int MUL_W    = OFF_W + STEP_W + 1;
    localparam int SUM_W    = MUL_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'($signed(32'h7FFF_FFFF));
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'($signed(32'h8000_0000));

    logic                    r_s1_v;
    logic [PIX_W-1:0]        r_s1_px;
    logic [PIX_W-1:0]        r_s1_py;
    logic                    r_s2_v;
    logic [PIX_W-1:0]        r_s2_px;
    logic [PIX_W-1:0]        r_s2_py;
    logic signed [MUL_W-1:0] r_s2_mx;
    logic signed [MUL_W-1:0] r_s2_my;

    logic                    w_en2;
    logic                    w_en1;
    logic signed [OFF_W-1:0] w_off_x;
    logic signed [OFF_W-1:0] w_off_y;
    logic signed [Q_W-1:0]   w_step;
    logic signed [MUL_W-1:0] w_mul_x;
    logic signed [MUL_W-1:0] w_mul_y;
    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_y;
    logic signed [Q_W-1:0]   w_cr;
    logic signed [Q_W-1:0]   w_ci;

    assign w_en2   = !r_s2_v || !i_full;
    assign w_en1   = !r_s1_v || w_en2;
    assign o_stall = !w_en1;
    assign o_push  = r_s2_v && !i_full;

    // offset from image middle, times step
    assign w_off_x = $signed(OFF_W'(r_s1_px)) - $signed(OFF_W'(HALF_X));
    assign w_off_y = $signed(OFF_W'(r_s1_py)) - $signed(OFF_W'(HALF_Y));
    assign w_step  = $signed({1'b0, i_cfg.pixel_step});
    assign w_mul_x = MUL_W'(w_off_x) * MUL_W'(w_step);
    assign w_mul_y = MUL_W'(w_off_y) * MUL_W'(w_step);

    assign w_sum_x = SUM_W'(r_s2_mx) + SUM_W'(i_cfg.centre_real);
    assign w_sum_y = SUM_W'(r_s2_my) + SUM_W'(i_cfg.centre_imag);

    always_comb begin
        if (w_sum_x > SAT_HI) begin
            w_cr = SAT_HI[Q_W-1:0];
        end else if (w_sum_x < SAT_LO) begin
            w_cr = SAT_LO[Q_W-1:0];
        end else begin
            w_cr = w_sum_x[Q_W-1:0];
        end
        if (w_sum_y > SAT_HI) begin
            w_ci = SAT_HI[Q_W-1:0];
        end else if (w_sum_y < SAT_LO) begin
            w_ci = SAT_LO[Q_W-1:0];
        end else begin
            w_ci = w_sum_y[Q_W-1:0];
        end
    end

    assign o_job = '{px: r_s2_px, py: r_s2_py, cr: w_cr, ci: w_ci};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_v <= i_valid;
            end
            if (w_en2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_s1_px <= i_px;
            r_s1_py <= i_py;
        end
        if (w_en2) begin
            r_s2_px <= r_s1_px;
            r_s2_py <= r_s1_py;
            r_s2_mx <= w_mul_x;
            r_s2_my <= w_mul_y;
        end
    end

endmodule

// ----- sv/mbe_queue.sv -----
// Small job queue between the mapping front end and the iteration engine.
module mbe_queue
    import mbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");

endmodule

// ----- sv/mbe_back.sv -----
// Iteration engine: runs z = z*z + c until escape or the limit, holds the result.
module mbe_back
    import mbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_job             i_job,
    output logic             o_pop,
    input  logic [CNT_W-1:0] i_limit,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_result          o_result
);

    // (zr*zi >>> 27) spans 37 bits, plus c and a guard bit
    localparam int UPD_W = PROD_W - (FRAC - 1) + 1;
    localparam logic signed [UPD_W-1:0] SAT_HI = UPD_W'($signed(32'h7FFF_FFFF));
    localparam logic signed [UPD_W-1:0] SAT_LO = UPD_W'($signed(32'h8000_0000));

    t_state                   r_state;
    logic signed [Q_W-1:0]    r_zr;
    logic signed [Q_W-1:0]    r_zi;
    logic signed [Q_W-1:0]    r_cr;
    logic signed [Q_W-1:0]    r_ci;
    logic [PIX_W-1:0]         r_px;
    logic [PIX_W-1:0]         r_py;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [PROD_W-1:0] r_rr;
    logic signed [PROD_W-1:0] r_ii;
    logic signed [PROD_W-1:0] r_ri;
    logic signed [PROD_W-1:0] r_dif;
    logic                     r_ov;
    t_result                  r_res;

    logic [CNT_W-1:0]         w_lim;
    logic [CNT_W-1:0]         n_cnt;
    logic [PROD_W-1:0]        w_mag;
    logic signed [UPD_W-1:0]  w_sr;
    logic signed [UPD_W-1:0]  w_si;
    logic signed [Q_W-1:0]    n_zr;
    logic signed [Q_W-1:0]    n_zi;
    logic                     w_take;

    assign w_lim  = (i_limit == '0) ? CNT_W'(1) : i_limit;
    assign n_cnt  = r_cnt + 1'b1;
    assign w_mag  = $unsigned(r_rr) + $unsigned(r_ii);
    assign o_pop  = (r_state == ST_IDLE) && !i_empty;
    assign w_take = (r_state == ST_FIN) && (!r_ov || !i_out_stall);

    assign o_out_valid = r_ov;
    assign o_result    = r_res;

    // floor shifts are arithmetic shifts
    assign w_sr = UPD_W'(r_dif >>> FRAC) + UPD_W'(r_cr);
    assign w_si = UPD_W'(r_ri >>> (FRAC - 1)) + UPD_W'(r_ci);

    always_comb begin
        if (w_sr > SAT_HI) begin
            n_zr = SAT_HI[Q_W-1:0];
        end else if (w_sr < SAT_LO) begin
            n_zr = SAT_LO[Q_W-1:0];
        end else begin
            n_zr = w_sr[Q_W-1:0];
        end
        if (w_si > SAT_HI) begin
            n_zi = SAT_HI[Q_W-1:0];
        end else if (w_si < SAT_LO) begin
            n_zi = SAT_LO[Q_W-1:0];
        end else begin
            n_zi = w_si[Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (w_take) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (w_lim == CNT_W'(1)) ? ST_FIN : ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (w_mag >= ESCAPE_MAG || n_cnt >= w_lim) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_UPD;
                    end
                end
                ST_FIN: begin
                    if (w_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_px  <= i_job.px;
                    r_py  <= i_job.py;
                    r_cr  <= i_job.cr;
                    r_ci  <= i_job.ci;
                    r_cnt <= CNT_W'(1);
                    r_dif <= '0;
                    r_ri  <= '0;
                end
            end
            ST_UPD: begin
                r_zr <= n_zr;
                r_zi <= n_zi;
            end
            ST_MUL: begin
                r_rr <= r_zr * r_zr;
                r_ii <= r_zi * r_zi;
                r_ri <= r_zr * r_zi;
            end
            ST_CHK: begin
                // an escape keeps the count of the iteration that escaped
                if (w_mag < ESCAPE_MAG) begin
                    r_cnt <= n_cnt;
                    r_dif <= r_rr - r_ii;
                end
            end
            ST_FIN: begin
                if (w_take) begin
                    r_res <= '{x: r_px, y: r_py, count: r_cnt, in_set: (r_cnt == w_lim)};
                end
            end
            default: begin
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt <= w_lim)) else $error("count beyond limit");
    a_upd_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> (r_state == ST_MUL)) else $error("update not followed by multiply");
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_ov && r_state == ST_IDLE)) else $error("result not loaded");

endmodule

// ----- sv/mandelbrot_escape_time.sv -----
// Top level of the Mandelbrot escape-time unit: config registers and datapath wiring.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------------------
//  pixel in  | i_in_valid / o_in_stall      | i_pixel_x, i_pixel_y
//  result    | o_out_valid / i_out_stall    | o_out_x, o_out_y, o_escape_count,
//            |                              | o_inside_set
//  config    | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Each iteration in the engine runs the update, multiply and check states, up to
// iteration_limit - 1 iterations per pixel. Mapping is registered through stages s1
// and s2 ahead of a 4-entry queue, so pixels keep flowing in while the engine
// iterates, until the queue is full. Reset is synchronous, active low, and restores
// the register defaults. A stalled result holds; the engine waits with the next one.
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel_x,
    input  logic [PIX_W-1:0]     i_pixel_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_out_x,
    output logic [PIX_W-1:0]     o_out_y,
    output logic [CNT_W-1:0]     o_escape_count,
    output logic                 o_inside_set,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    w_push;
    t_job    w_push_job;
    logic    w_full;
    logic    w_pop;
    t_job    w_pop_job;
    logic    w_empty;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{centre_real: CENTRE_RST, centre_imag: CENTRE_RST,
                       pixel_step: STEP_RST, iteration_limit: LIMIT_RST};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CENTRE_REAL:     r_cfg.centre_real     <= $signed(i_cfg_data);
                CFG_CENTRE_IMAG:     r_cfg.centre_imag     <= $signed(i_cfg_data);
                CFG_PIXEL_STEP:      r_cfg.pixel_step      <= i_cfg_data[STEP_W-1:0];
                CFG_ITERATION_LIMIT: r_cfg.iteration_limit <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mbe_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_px    (i_pixel_x),
        .i_py    (i_pixel_y),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_full)
    );

    mbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_empty)
    );

    mbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .i_limit     (r_cfg.iteration_limit),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_res)
    );

    assign o_out_x        = w_res.x;
    assign o_out_y        = w_res.y;
    assign o_escape_count = w_res.count;
    assign o_inside_set   = w_res.in_set;

endmodule
